>>> sv/qrt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrt_pkg: shared types and constants of the routing estimate table
// Sizes, op codes, register indexes and the controller command struct.
// ----------------------------------------------------------------------------
package qrt_pkg;

   localparam int NODE_COUNT    = 64;
   localparam int NEIGHBOR_DIRS = 4;
   localparam int ESTIMATE_BITS = 16;
   localparam int NODE_BITS     = 6;
   localparam int DIR_BITS      = 2;
   localparam int ADDR_BITS     = DIR_BITS + NODE_BITS;
   localparam logic [ESTIMATE_BITS-1:0] Q_INF = '1;
   localparam logic [2:0] LOCAL_DIR = 3'd4;

   localparam logic [1:0] OP_ROUTE = 2'd0;
   localparam logic [1:0] OP_LEARN = 2'd1;
   localparam logic [1:0] OP_FILL  = 2'd2;
   localparam logic [1:0] OP_SHIFT = 2'd3;

   localparam logic [2:0] REG_OWN_ID     = 3'd0;
   localparam logic [2:0] REG_PRESENT    = 3'd1;
   localparam logic [2:0] REG_NORTH      = 3'd2;
   localparam logic [2:0] REG_EAST       = 3'd3;
   localparam logic [2:0] REG_SOUTH      = 3'd4;
   localparam logic [2:0] REG_WEST       = 3'd5;
   localparam logic [2:0] REG_LEARN_RATE = 3'd6;
   localparam logic [2:0] REG_LQT        = 3'd7;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD,        // issue reads (route: dir counter; learn: one entry)
      ST_RD_WAIT,   // last read data lands
      ST_DECIDE,    // route decision
      ST_L_MUL,     // learn multiply
      ST_L_WR,      // learn write
      ST_S_RD,      // shift sweep read
      ST_S_MUL,     // shift multiply
      ST_S_WR,      // shift write
      ST_F_WR,      // fill sweep write
      ST_OUT        // result held
   } state_type;

   typedef struct packed {
      logic       load;       // capture request
      logic       clr_cnt;
      logic       inc_cnt;
      logic       rd_route;   // read entry (cnt dir, dest)
      logic       rd_learn;   // read entry (dir_sel, dest)
      logic       rd_sweep;   // read entry (dir_sel, cnt node)
      logic       cap_route;  // fold read data into route compare
      logic       decide;
      logic       mul;
      logic       wr_learn;
      logic       wr_fill;
      logic       wr_shift;
      logic       out_valid;
   } cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       cnt_last_dir;
      logic       cnt_last_node;
      logic       learn_ok;
      logic       sweep_ok;
   } status_type;

endpackage

>>> sv/qrt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrt_ctrl: sequencer of the routing estimate table
// Steps each request through its read, arithmetic and write phases.
// ----------------------------------------------------------------------------
module qrt_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_fire,
   input  logic               rsp_fire,
   input  qrt_pkg::status_type sts,
   output qrt_pkg::cmd_type   cmd,
   output logic               req_tready
);
   import qrt_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:    if (req_fire) state_in = ST_RD;
         ST_RD: begin
            unique case (sts.op)
               OP_ROUTE: if (sts.cnt_last_dir) state_in = ST_RD_WAIT;
               OP_LEARN: state_in = sts.learn_ok ? ST_RD_WAIT : ST_OUT;
               OP_FILL:  state_in = sts.sweep_ok ? ST_F_WR : ST_OUT;
               default:  state_in = sts.sweep_ok ? ST_S_RD : ST_OUT;
            endcase
         end
         ST_RD_WAIT: state_in = (sts.op == OP_ROUTE) ? ST_DECIDE : ST_L_MUL;
         ST_DECIDE:  state_in = ST_OUT;
         ST_L_MUL:   state_in = ST_L_WR;
         ST_L_WR:    state_in = ST_OUT;
         ST_S_RD:    state_in = ST_S_MUL;
         ST_S_MUL:   state_in = ST_S_WR;
         ST_S_WR:    state_in = sts.cnt_last_node ? ST_OUT : ST_S_RD;
         ST_F_WR:    if (sts.cnt_last_node) state_in = ST_OUT;
         ST_OUT:     if (rsp_fire) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.load    = req_fire;
            cmd.clr_cnt = 1'b1;
         end
         ST_RD: begin
            if (sts.op == OP_ROUTE) begin
               cmd.rd_route = 1'b1;
               cmd.inc_cnt  = 1'b1;
            end else if (sts.op == OP_LEARN) begin
               cmd.rd_learn = 1'b1;
            end
         end
         ST_RD_WAIT: cmd.cap_route = (sts.op == OP_ROUTE);
         ST_DECIDE:  cmd.decide = 1'b1;
         ST_L_MUL:   cmd.mul = 1'b1;
         ST_L_WR:    cmd.wr_learn = 1'b1;
         ST_S_RD:    cmd.rd_sweep = 1'b1;
         ST_S_MUL:   cmd.mul = 1'b1;
         ST_S_WR: begin
            cmd.wr_shift = 1'b1;
            cmd.inc_cnt  = 1'b1;
         end
         ST_F_WR: begin
            cmd.wr_fill = 1'b1;
            cmd.inc_cnt = 1'b1;
         end
         ST_OUT:     cmd.out_valid = 1'b1;
         default:    cmd = '0;
      endcase
      // Route read data is registered; fold the previous read while reading the next.
      if (state_ff == ST_RD && sts.op == OP_ROUTE) cmd.cap_route = 1'b1;
   end

endmodule

>>> sv/qrt_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrt_datapath: estimate memory, compare and update arithmetic
// Holds the request, the registers and the table; computes the result.
// ----------------------------------------------------------------------------
module qrt_datapath (
   input  logic                clock,
   input  logic                reset,
   input  qrt_pkg::cmd_type    cmd,
   output qrt_pkg::status_type sts,
   input  logic [47:0]         req_tdata,
   input  logic                csr_we,
   input  logic [2:0]          csr_index,
   input  logic [15:0]         csr_wdata,
   output logic [9:0]          rsp_tdata,
   output logic                rsp_tvalid
);
   import qrt_pkg::*;

   localparam int EB = ESTIMATE_BITS;

   // Registers.
   logic [NODE_BITS-1:0]     own_id_ff;
   logic [NEIGHBOR_DIRS-1:0] present_ff;
   logic [NODE_BITS-1:0]     nb_node_ff [NEIGHBOR_DIRS];
   logic [8:0]               learn_rate_ff;
   logic [EB-1:0]            lqt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         own_id_ff     <= '0;
         present_ff    <= '0;
         for (int i = 0; i < NEIGHBOR_DIRS; i++) nb_node_ff[i] <= '0;
         learn_rate_ff <= 9'd128;
         lqt_ff        <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_OWN_ID:     own_id_ff     <= csr_wdata[NODE_BITS-1:0];
            REG_PRESENT:    present_ff    <= csr_wdata[NEIGHBOR_DIRS-1:0];
            REG_NORTH:      nb_node_ff[0] <= csr_wdata[NODE_BITS-1:0];
            REG_EAST:       nb_node_ff[1] <= csr_wdata[NODE_BITS-1:0];
            REG_SOUTH:      nb_node_ff[2] <= csr_wdata[NODE_BITS-1:0];
            REG_WEST:       nb_node_ff[3] <= csr_wdata[NODE_BITS-1:0];
            REG_LEARN_RATE: learn_rate_ff <= csr_wdata[8:0];
            REG_LQT:        lqt_ff        <= csr_wdata[EB-1:0];
            default:        ;
         endcase
      end
   end

   // Captured request.
   logic [1:0]           op_ff;
   logic [NODE_BITS-1:0] dest_ff;
   logic [2:0]           dsel_ff;
   logic [EB-1:0]        val_ff;
   logic [7:0]           nd_ff, pd_ff;
   logic                 gate_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= req_tdata[1:0];
         dest_ff <= req_tdata[7:2];
         dsel_ff <= req_tdata[10:8];
         val_ff  <= req_tdata[26:11];
         nd_ff   <= req_tdata[34:27];
         pd_ff   <= req_tdata[42:35];
         gate_ff <= req_tdata[43];
      end
   end

   logic dsel_ok;
   assign dsel_ok = (dsel_ff < 3'(NEIGHBOR_DIRS)) && present_ff[dsel_ff[DIR_BITS-1:0]];

   // Counter: direction for route reads, node for sweeps.
   logic [NODE_BITS:0] cnt_ff;
   always_ff @(posedge clock) begin
      if (cmd.clr_cnt)      cnt_ff <= '0;
      else if (cmd.inc_cnt) cnt_ff <= cnt_ff + 1'b1;
   end

   // Estimate memory.
   logic [EB-1:0]        mem [NEIGHBOR_DIRS*NODE_COUNT];
   logic [EB-1:0]        rd_data_ff;
   logic [ADDR_BITS-1:0] rd_addr, wr_addr;
   logic                 rd_en, wr_en;
   logic [EB-1:0]        wr_data;

   always_comb begin
      rd_en = cmd.rd_route | cmd.rd_learn | cmd.rd_sweep;
      if (cmd.rd_route)      rd_addr = {cnt_ff[DIR_BITS-1:0], dest_ff};
      else if (cmd.rd_sweep) rd_addr = {dsel_ff[DIR_BITS-1:0], cnt_ff[NODE_BITS-1:0]};
      else                   rd_addr = {dsel_ff[DIR_BITS-1:0], dest_ff};
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   // Route compare: estimates folded one per cycle.
   logic                     rd_pend_ff;
   logic [DIR_BITS-1:0]      rd_dir_ff;
   logic [EB-1:0]            q_ff [NEIGHBOR_DIRS];
   always_ff @(posedge clock) begin
      rd_pend_ff <= cmd.rd_route;
      rd_dir_ff  <= cnt_ff[DIR_BITS-1:0];
      if (cmd.cap_route && rd_pend_ff) q_ff[rd_dir_ff] <= rd_data_ff;
   end

   // Lowest-numbered minimum below infinity among the enabled directions.
   function automatic logic [NEIGHBOR_DIRS+DIR_BITS:0] best_of(
      input logic [EB-1:0] q [NEIGHBOR_DIRS], input logic [NEIGHBOR_DIRS-1:0] en);
      logic [EB-1:0]            mn;
      logic                     fnd;
      logic [DIR_BITS-1:0]      bd;
      logic [NEIGHBOR_DIRS-1:0] m;
      mn = Q_INF; fnd = 1'b0; bd = '0; m = '0;
      for (int d = 0; d < NEIGHBOR_DIRS; d++) begin
         if (en[d]) begin
            if (q[d] < mn) begin
               mn = q[d]; fnd = 1'b1; bd = DIR_BITS'(d);
               m = '0; m[d] = 1'b1;
            end else if (q[d] == mn && fnd) begin
               m[d] = 1'b1;
            end
         end
      end
      return {fnd, bd, m};
   endfunction

   logic [NEIGHBOR_DIRS-1:0] en_all, en_excl;
   logic [NEIGHBOR_DIRS+DIR_BITS:0] r_all, r_excl;
   logic                     hit_f;
   logic [DIR_BITS-1:0]      hit_d;
   logic [2:0]               dout_c;
   logic                     found_c, upd_c;
   logic [NEIGHBOR_DIRS-1:0] mask_c;
   logic                     dest_in_range;

   always_comb begin
      dest_in_range = 32'(dest_ff) < NODE_COUNT;
      en_all = dest_in_range ? present_ff : '0;
      en_excl = en_all;
      if (dsel_ff < 3'(NEIGHBOR_DIRS)) en_excl[dsel_ff[DIR_BITS-1:0]] = 1'b0;
      r_all  = best_of(q_ff, en_all);
      r_excl = best_of(q_ff, en_excl);
      hit_f = 1'b0; hit_d = '0;
      for (int i = NEIGHBOR_DIRS-1; i >= 0; i--) begin
         if (present_ff[i] && nb_node_ff[i] == dest_ff) begin
            hit_f = 1'b1; hit_d = DIR_BITS'(i);
         end
      end
      dout_c = '0; found_c = 1'b0; mask_c = '0; upd_c = 1'b1;
      if (dest_ff == own_id_ff) begin
         dout_c = LOCAL_DIR; found_c = 1'b1; upd_c = 1'b0;
      end else if (hit_f) begin
         dout_c = {1'b0, hit_d}; found_c = 1'b1;
         mask_c[hit_d] = 1'b1;
         upd_c = r_all[NEIGHBOR_DIRS+DIR_BITS] &&
                 (r_all[NEIGHBOR_DIRS+DIR_BITS-1:NEIGHBOR_DIRS] == hit_d);
      end else begin
         mask_c = r_excl[NEIGHBOR_DIRS-1:0];
         if (dsel_ff < 3'(NEIGHBOR_DIRS) && r_all[dsel_ff[DIR_BITS-1:0]]) upd_c = 1'b0;
         // The excluded search equals the plain one unless best is arrival.
         if (r_excl[NEIGHBOR_DIRS+DIR_BITS]) begin
            dout_c = {1'b0, r_excl[NEIGHBOR_DIRS+DIR_BITS-1:NEIGHBOR_DIRS]};
            found_c = 1'b1;
         end
         if (!(r_all[NEIGHBOR_DIRS+DIR_BITS] && dsel_ff < 3'(NEIGHBOR_DIRS) &&
               r_all[NEIGHBOR_DIRS+DIR_BITS-1:NEIGHBOR_DIRS] == dsel_ff[DIR_BITS-1:0])) begin
            dout_c  = {1'b0, r_all[NEIGHBOR_DIRS+DIR_BITS-1:NEIGHBOR_DIRS]};
            found_c = r_all[NEIGHBOR_DIRS+DIR_BITS];
         end
      end
   end

   // Learn and shift arithmetic: one multiply, registered.
   logic signed [EB+2:0]  diff;     // lqt + val - q
   logic signed [EB+12:0] prod_ff;  // eta * diff or val * (nd - pd)
   logic signed [9:0]     eta_s;
   logic signed [8:0]     ddiv;
   always_comb begin
      eta_s = (learn_rate_ff > 9'd256) ? 10'sd256 : signed'({1'b0, learn_rate_ff});
      diff  = signed'((EB+3)'(lqt_ff)) + signed'((EB+3)'(val_ff))
            - signed'((EB+3)'(rd_data_ff));
      ddiv  = signed'({1'b0, nd_ff}) - signed'({1'b0, pd_ff});
   end
   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         if (op_ff == OP_LEARN) prod_ff <= (EB+13)'(diff * eta_s);
         else prod_ff <= (EB+13)'(signed'({1'b0, val_ff}) * ddiv);
      end
   end

   logic signed [EB+13:0] upd_sum;
   logic [EB-1:0]         upd_val;
   always_comb begin
      if (op_ff == OP_LEARN)
         upd_sum = signed'((EB+14)'(rd_data_ff)) + ((EB+14)'(prod_ff + 128) >>> 8);
      else
         upd_sum = signed'((EB+14)'(rd_data_ff)) + (EB+14)'(prod_ff);
      if (upd_sum < 0) upd_val = '0;
      else if (upd_sum > signed'((EB+14)'(Q_INF))) upd_val = Q_INF;
      else upd_val = upd_sum[EB-1:0];
   end

   logic not_own;
   assign not_own = cnt_ff[NODE_BITS-1:0] != own_id_ff;
   always_comb begin
      wr_en = 1'b0; wr_addr = {dsel_ff[DIR_BITS-1:0], dest_ff}; wr_data = upd_val;
      if (cmd.wr_learn && rd_data_ff != Q_INF) wr_en = 1'b1;
      if (cmd.wr_fill || cmd.wr_shift) begin
         wr_addr = {dsel_ff[DIR_BITS-1:0], cnt_ff[NODE_BITS-1:0]};
         wr_en   = not_own;
         if (cmd.wr_fill) wr_data = val_ff;
      end
   end

   // Result register.
   logic [2:0]               dout_ff;
   logic                     found_ff, upd_ff, chg_ff;
   logic [NEIGHBOR_DIRS-1:0] mask_ff;
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         dout_ff <= '0; found_ff <= 1'b0; mask_ff <= '0; upd_ff <= 1'b0; chg_ff <= 1'b0;
      end else begin
         if (cmd.decide) begin
            dout_ff <= dout_c; found_ff <= found_c; mask_ff <= mask_c; upd_ff <= upd_c;
         end
         if (wr_en) chg_ff <= 1'b1;
      end
   end

   assign rsp_tdata  = {chg_ff, upd_ff, mask_ff, found_ff, dout_ff};
   assign rsp_tvalid = cmd.out_valid;

   always_comb begin
      sts.op            = op_ff;
      sts.cnt_last_dir  = cnt_ff[DIR_BITS-1:0] == DIR_BITS'(NEIGHBOR_DIRS-1);
      sts.cnt_last_node = cnt_ff[NODE_BITS-1:0] == NODE_BITS'(NODE_COUNT-1);
      sts.learn_ok      = gate_ff && dsel_ok && dest_ff != own_id_ff &&
                          dest_in_range && val_ff != Q_INF;
      sts.sweep_ok      = dsel_ok;
   end

endmodule

>>> sv/q_routing_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q_routing_table_core: Q-routing estimate table of a four-neighbor router
// Top level joining the sequencer and the table datapath.
// ----------------------------------------------------------------------------
// One request is handled at a time. A route request issues four estimate
// reads through the table's single read port, waits for the last read to
// land and then decides. A learn reads, multiplies and writes. A fill walks
// all 64 destinations one write a cycle; a shift reads, multiplies and
// writes each destination in turn. Learn, fill and shift requests with an
// absent or local direction go straight to the result. The result is held
// until taken, and a new request can be accepted in the cycle after the
// result is taken. The table must be filled by software before any entry
// is read.
module q_routing_table_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // op[1:0], dest[7:2], dir_sel[10:8], value[26:11], new_division[34:27],
   // prev_division[42:35], learn_gate[43], zero fill above.
   input  logic [47:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // dir_out[2:0], route_found[3], min_mask[7:4], update_ok[8],
   // table_changed[9], zero fill above.
   output logic [15:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import qrt_pkg::*;

   cmd_type    cmd;
   status_type sts;
   logic       req_fire, rsp_fire;
   logic [9:0] rsp_bits;

   assign req_fire = req_tvalid & req_tready;
   assign rsp_fire = rsp_tvalid & rsp_tready;

   qrt_ctrl u_ctrl (
      .clock, .reset, .req_fire, .rsp_fire, .sts, .cmd, .req_tready
   );

   qrt_datapath u_dp (
      .clock, .reset, .cmd, .sts, .req_tdata, .csr_we, .csr_index, .csr_wdata,
      .rsp_tdata(rsp_bits), .rsp_tvalid
   );

   assign rsp_tdata = {6'd0, rsp_bits};

endmodule

>>> tb/tb_q_routing_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_q_routing_table_core: self-checking bench for the routing estimate table
// A queue-fed driver offers requests on the request stream, and a monitor
// checks every response against an in-bench model of the table.
// ----------------------------------------------------------------------------
// The bench keeps its own copy of the estimate table and of the registers.
// When a request is accepted, the bench computes the response it expects
// and queues it. The monitor compares each response field by field with the
// oldest queued response. The table is filled completely before the first
// read, so no entry that was never written is ever read. Registers change
// only while the block is idle. The run has a directed part and then four
// random phases. Each random phase uses its own setting and its own idling
// pattern.
module tb_q_routing_table_core;
   import qrt_pkg::*;

   typedef struct packed {
      logic        learn_gate;
      logic [7:0]  prev_div;
      logic [7:0]  new_div;
      logic [15:0] value;
      logic [2:0]  dir_sel;
      logic [5:0]  dest;
      logic [1:0]  op;
   } request_t;

   typedef struct packed {
      logic       changed;
      logic       update_ok;
      logic [3:0] min_mask;
      logic       found;
      logic [2:0] dir_out;
   } answer_t;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [15:0] csr_wdata;

   q_routing_table_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // These are the model's copy of the table and of the registers.
   logic [15:0] est_table [4][64];
   logic [5:0]  own_node;
   logic [3:0]  present_mask;
   logic [5:0]  nb_node [4];
   logic [8:0]  learn_rate;
   logic [15:0] queue_time;

   request_t pending_requests [$];
   answer_t  expected_answers [$];
   int       error_count = 0;
   int       send_idle_pct = 0;
   int       recv_stall_pct = 0;
   bit       send_pause = 0;
   bit       hold_rsp = 0;
   bit       req_taken = 0;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // This returns the lowest present direction with the smallest estimate
   // below infinity, skipping the excluded direction. The mask gets every
   // direction that ties with that minimum.
   function automatic int best_direction(int dest, int excl, output logic [3:0] tie_mask);
      longint lowest;
      int     pick;
      lowest   = 65535;
      pick     = -1;
      tie_mask = '0;
      for (int d = 0; d < 4; d++) begin
         if (d == excl || !present_mask[d]) continue;
         if (est_table[d][dest] < lowest) begin
            lowest   = est_table[d][dest];
            pick     = d;
            tie_mask = 4'b0001 << d;
         end else if (est_table[d][dest] == lowest && pick >= 0) begin
            tie_mask[d] = 1'b1;
         end
      end
      return pick;
   endfunction

   function automatic longint clamp_estimate(longint v);
      if (v < 0) return 0;
      if (v > 65535) return 65535;
      return v;
   endfunction

   // This computes the response to one request and updates the table copy.
   function automatic answer_t route_and_learn(request_t r);
      answer_t    a;
      logic [3:0] all_mask, dummy;
      int         best, hit, pick, dsel, dest;
      longint     eta, diff, prod, q;
      a    = '0;
      dsel = r.dir_sel;
      dest = r.dest;
      if (r.op == OP_ROUTE) begin
         best        = best_direction(dest, 255, all_mask);
         hit         = -1;
         a.update_ok = 1'b1;
         for (int d = 3; d >= 0; d--)
            if (present_mask[d] && nb_node[d] == r.dest) hit = d;
         if (r.dest == own_node) begin
            a.dir_out   = LOCAL_DIR;
            a.found     = 1'b1;
            a.update_ok = 1'b0;
         end else if (hit >= 0) begin
            a.dir_out   = 3'(hit);
            a.found     = 1'b1;
            a.min_mask  = 4'b0001 << hit;
            a.update_ok = (best == hit);
         end else begin
            void'(best_direction(dest, dsel, a.min_mask));
            if (dsel < 4 && all_mask[dsel]) a.update_ok = 1'b0;
            // On a U-turn the best of the other directions is taken.
            if (best >= 0 && best == dsel) pick = best_direction(dest, dsel, dummy);
            else pick = best;
            if (pick >= 0) begin
               a.dir_out = 3'(pick);
               a.found   = 1'b1;
            end
         end
      end else if (r.op == OP_LEARN) begin
         if (r.learn_gate && dsel < 4 && present_mask[dsel] && r.dest != own_node) begin
            q = est_table[dsel][dest];
            if (q < 65535 && r.value < 16'hFFFF) begin
               eta  = (learn_rate > 256) ? 256 : learn_rate;
               diff = longint'(queue_time) + longint'(r.value) - q;
               prod = eta * diff + 128;
               // Division by 256 rounds toward minus infinity after the bias.
               prod = (prod >= 0) ? prod / 256 : -((-prod + 255) / 256);
               est_table[dsel][dest] = 16'(clamp_estimate(q + prod));
               a.changed = 1'b1;
            end
         end
      end else if (dsel < 4 && present_mask[dsel]) begin
         for (int n = 0; n < 64; n++) begin
            if (n == own_node) continue;
            if (r.op == OP_FILL) est_table[dsel][n] = r.value;
            else est_table[dsel][n] = 16'(clamp_estimate(longint'(est_table[dsel][n]) +
               longint'(r.value) * (longint'(r.new_div) - longint'(r.prev_div))));
            a.changed = 1'b1;
         end
      end
      return a;
   endfunction

   task automatic report_mismatch(string field, int got, int want);
      $display("%0t: mismatch in %s: got %0d, expected %0d", $time, field, got, want);
      error_count++;
   endtask

   // The driver presents requests at the falling edge. A request stays on the
   // bus until the rising edge at which it is taken.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         if (!req_tvalid || req_taken) begin
            if (pending_requests.size() != 0 && !send_pause &&
                $urandom_range(99) >= send_idle_pct) begin
               req_tdata  <= {4'b0, pending_requests.pop_front()};
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         rsp_tready <= !hold_rsp && ($urandom_range(99) >= recv_stall_pct);
      end
      req_taken = 1'b0;
   end

   // The monitor samples both handshakes at the rising edge.
   always @(posedge clock) begin
      answer_t got, want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            expected_answers.insert(expected_answers.size(),
                                    route_and_learn(request_t'(req_tdata[43:0])));
            req_taken = 1'b1;
         end
         if (rsp_tvalid && rsp_tready) begin
            got = answer_t'(rsp_tdata[9:0]);
            if (expected_answers.size() == 0) begin
               $display("%0t: response with no request outstanding", $time);
               error_count++;
            end else begin
               want = expected_answers.pop_front();
               if (got.dir_out !== want.dir_out)
                  report_mismatch("dir_out", got.dir_out, want.dir_out);
               if (got.found !== want.found)
                  report_mismatch("route_found", got.found, want.found);
               if (got.min_mask !== want.min_mask)
                  report_mismatch("min_mask", got.min_mask, want.min_mask);
               if (got.update_ok !== want.update_ok)
                  report_mismatch("update_ok", got.update_ok, want.update_ok);
               if (got.changed !== want.changed)
                  report_mismatch("table_changed", got.changed, want.changed);
            end
         end
      end
   end

   // Registers are written only at the falling edge while the block is idle.
   task automatic write_reg(logic [2:0] index, int data);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= 16'(data);
      case (index)
         REG_OWN_ID:     own_node = 6'(data);
         REG_PRESENT:    present_mask = 4'(data);
         REG_NORTH:      nb_node[0] = 6'(data);
         REG_EAST:       nb_node[1] = 6'(data);
         REG_SOUTH:      nb_node[2] = 6'(data);
         REG_WEST:       nb_node[3] = 6'(data);
         REG_LEARN_RATE: learn_rate = 9'(data);
         default:        queue_time = 16'(data);
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic add_request(logic [1:0] op, int dest, int dsel, int value,
                              int new_div = 1, int prev_div = 1, bit gate = 1);
      request_t r;
      r.op         = op;
      r.dest       = 6'(dest);
      r.dir_sel    = 3'(dsel);
      r.value      = 16'(value);
      r.new_div    = 8'(new_div);
      r.prev_div   = 8'(prev_div);
      r.learn_gate = gate;
      pending_requests.insert(pending_requests.size(), r);
   endtask

   // This blocks until every queued request is accepted and answered.
   task automatic drain;
      while (pending_requests.size() != 0 || req_tvalid || expected_answers.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   function automatic int random_value();
      case ($urandom_range(5))
         0:       return $urandom_range(65535);
         1:       return 65535;
         2:       return $urandom_range(1) ? 0 : 65534;
         default: return $urandom_range(4095);
      endcase
   endfunction

   // Most random requests are routes and learns, and half of them go toward
   // the neighbors or this node, so that the special routing cases come up often.
   task automatic add_random_request();
      int dest, dsel, kind, nd;
      case ($urandom_range(3))
         0:       dest = own_node;
         1:       dest = nb_node[$urandom_range(3)];
         default: dest = $urandom_range(63);
      endcase
      dsel = $urandom_range(4);
      kind = $urandom_range(99);
      if (kind < 45) begin
         add_request(OP_ROUTE, dest, dsel, $urandom_range(65535),
                     $urandom_range(1, 255), $urandom_range(1, 255), $urandom_range(1));
      end else if (kind < 80) begin
         add_request(OP_LEARN, dest, dsel, random_value(), $urandom_range(1, 255),
                     $urandom_range(1, 255), $urandom_range(9) != 0);
      end else if (kind < 90) begin
         add_request(OP_FILL, dest, dsel, random_value());
      end else begin
         nd = $urandom_range(1, 255);
         if ($urandom_range(3) != 0)
            add_request(OP_SHIFT, dest, dsel, $urandom_range(63),
                        nd, $urandom_range(nd > 3 ? nd - 3 : 1, nd < 252 ? nd + 3 : 255));
         else
            add_request(OP_SHIFT, dest, dsel, random_value(), nd, $urandom_range(1, 255));
      end
   endtask

   initial begin
      int rates [6] = '{0, 1, 128, 255, 256, 200};
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      rsp_tready = 1'b0;
      csr_we     = 1'b0;
      csr_index  = REG_OWN_ID;
      csr_wdata  = '0;
      own_node     = 0;
      present_mask = 0;
      nb_node      = '{0, 0, 0, 0};
      learn_rate   = 128;
      queue_time   = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // The table is filled in every direction twice, under two node numbers,
      // so that every entry is written before any read.
      write_reg(REG_PRESENT, 15);
      write_reg(REG_NORTH, 2);
      write_reg(REG_EAST, 3);
      write_reg(REG_SOUTH, 4);
      write_reg(REG_WEST, 63);
      write_reg(REG_LEARN_RATE, 256);
      for (int d = 0; d < 4; d++) add_request(OP_FILL, 9, d, 0);
      drain();
      write_reg(REG_OWN_ID, 1);
      add_request(OP_FILL, 0, 0, 100);
      add_request(OP_FILL, 0, 1, 200);
      add_request(OP_FILL, 0, 2, 100);
      add_request(OP_FILL, 0, 3, 65535);
      add_request(OP_ROUTE, 1, 0, 0);            // to this node
      add_request(OP_ROUTE, 3, 1, 0);            // to a neighbor that is not best
      add_request(OP_ROUTE, 10, 0, 0);           // U-turn on the best direction
      add_request(OP_ROUTE, 10, 4, 0);           // local arrival
      add_request(OP_ROUTE, 10, 3, 0);
      add_request(OP_LEARN, 10, 0, 50, 1, 1, 0); // gate low
      add_request(OP_LEARN, 10, 3, 50);          // entry at infinity
      add_request(OP_LEARN, 10, 0, 65535);       // value at infinity
      add_request(OP_LEARN, 11, 0, 65534);
      add_request(OP_LEARN, 1, 2, 7);            // own node
      add_request(OP_SHIFT, 5, 1, 65535, 255, 1);
      add_request(OP_SHIFT, 5, 0, 65535, 1, 255);
      add_request(OP_ROUTE, 20, 2, 0);
      for (int d = 0; d < 4; d++) add_request(OP_FILL, 0, d, 65535);
      add_request(OP_ROUTE, 20, 1, 0);           // nothing below infinity
      add_request(OP_SHIFT, 0, 3, 4, 7, 7);
      add_request(OP_FILL, 0, 4, 5);             // local direction
      drain();
      write_reg(REG_PRESENT, 5);
      write_reg(REG_LEARN_RATE, 0);
      write_reg(REG_LQT, 65535);
      add_request(OP_FILL, 0, 1, 5);             // absent direction
      add_request(OP_FILL, 0, 0, 300);
      add_request(OP_SHIFT, 0, 3, 9, 3, 2);
      add_request(OP_LEARN, 8, 1, 9);
      add_request(OP_LEARN, 8, 0, 9);
      add_request(OP_ROUTE, 8, 1, 0);
      drain();

      for (int phase = 0; phase < 4; phase++) begin
         write_reg(REG_OWN_ID, $urandom_range(63));
         write_reg(REG_PRESENT, (phase == 1) ? 0 : (phase == 0) ? 15 : $urandom_range(15));
         write_reg(REG_NORTH, $urandom_range(63));
         write_reg(REG_EAST, $urandom_range(63));
         write_reg(REG_SOUTH, $urandom_range(63));
         write_reg(REG_WEST, $urandom_range(63));
         write_reg(REG_LEARN_RATE, rates[$urandom_range(5)]);
         write_reg(REG_LQT, (phase == 3) ? 65535 : $urandom_range(1023));
         if (phase == 1) begin
            // With no neighbor present the table is read-only, so present
            // directions come back after a few requests.
            for (int i = 0; i < 20; i++) add_random_request();
            drain();
            write_reg(REG_PRESENT, $urandom_range(1, 15));
         end
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
            default: begin send_idle_pct = 19; recv_stall_pct = 19; end
         endcase
         for (int d = 0; d < 4; d++) add_request(OP_FILL, 0, d, $urandom_range(2047));
         for (int i = 0; i < 190; i++) add_random_request();
         if (phase == 0) begin
            // The receiver holds off for a long stretch while requests keep
            // coming, so the block fills up and stalls its input.
            hold_rsp = 1'b1;
            fork
               begin
                  repeat (600) @(posedge clock);
                  hold_rsp = 1'b0;
               end
            join_none
         end
         if (phase == 3) begin
            // Midway the sender stops until every response is back.
            while (pending_requests.size() > 95) @(negedge clock);
            send_pause = 1'b1;
            while (req_tvalid || expected_answers.size() != 0) @(negedge clock);
            send_pause = 1'b0;
         end
         drain();
      end

      send_idle_pct  = 0;
      recv_stall_pct = 0;
      repeat (20) @(posedge clock);
      if (error_count == 0 && expected_answers.size() == 0) begin
         $display("[q_routing_table_core] OK");
      end else begin
         $display("[q_routing_table_core] ERROR");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("timeout");
      $display("[q_routing_table_core] ERROR");
      $finish;
   end

endmodule

>>> files.f
sv/qrt_pkg.sv
sv/qrt_ctrl.sv
sv/qrt_datapath.sv
sv/q_routing_table_core.sv
tb/tb_q_routing_table_core.sv
